[sv/trilateration_2d_three_anchor_unit_defines.svh]
// ----------------------------------------------------------------------------
// trilateration assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef TRILATERATION_2D_THREE_ANCHOR_UNIT_DEFINES_SVH
`define TRILATERATION_2D_THREE_ANCHOR_UNIT_DEFINES_SVH

// property checked at every edge outside reset
`define TRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// combinational invariant, checked at every edge outside reset
`define TRI_ASSERT_ALWAYS(lbl, expr, msg) \
  `TRI_ASSERT(lbl, (1'b1 |-> (expr)), msg)

`endif

[sv/tri2d_pkg.sv]
// ----------------------------------------------------------------------------
// tri2d_pkg
// status codes and register indexes of the trilateration unit
// ----------------------------------------------------------------------------
package tri2d_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_A1X = 3'd0,
    REG_A1Y = 3'd1,
    REG_A2X = 3'd2,
    REG_A2Y = 3'd3,
    REG_A3X = 3'd4,
    REG_A3Y = 3'd5
  } reg_idx_e;

  localparam int unsigned CFG_ADDR_BITS = 3;

endpackage

[sv/tri2d_div.sv]
// ----------------------------------------------------------------------------
// tri2d_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module tri2d_div import tri2d_pkg::*; #(
  parameter int unsigned MW = 64,
  parameter int unsigned DW = 40,
  parameter int unsigned QB = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [MW-1:0] m_i,
  input  logic [DW-1:0] d_i,
  output logic [QB-1:0] q_o,
  output logic          over_o
);

  localparam int unsigned TW = MW + QB;

  logic [MW-1:0] rem_q [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic          ovr_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int unsigned K = QB - 1 - j;
    logic [MW-1:0] rin;
    logic [DW-1:0] din;
    logic [QB-1:0] qin;
    logic          oin;
    logic [TW-1:0] shifted;
    logic          take;

    if (j == 0) begin : g_first
      assign rin = m_i;
      assign din = d_i;
      assign qin = '0;
      // quotient would not fit in QB bits
      assign oin = TW'(m_i) >= (TW'(d_i) << QB);
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign din = den_q[j-1];
      assign qin = quo_q[j-1];
      assign oin = ovr_q[j-1];
    end

    assign shifted = TW'(din) << K;
    assign take    = TW'(rin) >= shifted;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? MW'(TW'(rin) - shifted) : rin;
        den_q[j] <= din;
        quo_q[j] <= qin | (QB'(take) << K);
        ovr_q[j] <= oin;
      end
    end
  end

  assign q_o    = quo_q[QB-1];
  assign over_o = ovr_q[QB-1];

endmodule

[sv/trilateration_2d_three_anchor_unit.sv]
// ----------------------------------------------------------------------------
// trilateration_2d_three_anchor_unit
// 2d tag position from three anchor ranges, cramer's rule, rounded result
// ----------------------------------------------------------------------------
// usage
//   in channel: range_a/b/c_i requests on in_valid_i / in_ready_o
//   out channel: pos_x_o, pos_y_o, status_o on out_valid_o / out_ready_i
//   cfg channel: anchor coordinates, index on cfg_addr_i, always ready
//   status: 0 ok, 1 singular anchor geometry (position zero), 2 saturated
// throughput
//   one request per cycle, sustained, while the receiver takes results
// pipeline
//   five arithmetic stages, COORD_BITS + 1 divider stages (one quotient
//   bit each) and one output stage, all registered; the first stage is
//   loaded at the accepting edge
// reset
//   pipeline valid bits clear, anchors return to their default positions
// stall
//   when out_ready_i is low with a result waiting, the whole pipeline
//   holds; in_ready_o drops, nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "trilateration_2d_three_anchor_unit_defines.svh"

module trilateration_2d_three_anchor_unit import tri2d_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned RANGE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_ADDR_BITS-1:0]     cfg_addr_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [RANGE_BITS-1:0]        range_a_i,
  input  logic [RANGE_BITS-1:0]        range_b_i,
  input  logic [RANGE_BITS-1:0]        range_c_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] pos_x_o,
  output logic signed [COORD_BITS-1:0] pos_y_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned RW  = RANGE_BITS;
  localparam int unsigned AW  = CW + 2;                       // matrix entries
  localparam int unsigned SQW = 2 * CW + 1;                   // coordinate squares
  localparam int unsigned RSW = 2 * RW + 1;                   // range squares
  localparam int unsigned BW  = ((2 * CW > 2 * RW) ? 2 * CW : 2 * RW) + 4;
  localparam int unsigned PW  = 2 * AW;
  localparam int unsigned DW  = PW + 1;                       // determinant
  localparam int unsigned XW  = BW + AW;
  localparam int unsigned NW  = XW + 1;                       // numerators
  localparam int unsigned MW  = NW + 1;                       // 2|n| + |d|
  localparam int unsigned D2W = DW + 1;                       // 2|d|
  localparam int unsigned QB  = CW + 1;
  localparam int unsigned LIM = 1 << (CW - 1);

  // anchor registers
  logic signed [CW-1:0] a1x_q, a1y_q, a2x_q, a2y_q, a3x_q, a3y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1x_q <= CW'(-660);
      a1y_q <= CW'(-100);
      a2x_q <= CW'(800);
      a2y_q <= CW'(280);
      a3x_q <= CW'(800);
      a3y_q <= CW'(-280);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_A1X: a1x_q <= cfg_data_i;
        REG_A1Y: a1y_q <= cfg_data_i;
        REG_A2X: a2x_q <= cfg_data_i;
        REG_A2Y: a2y_q <= cfg_data_i;
        REG_A3X: a3x_q <= cfg_data_i;
        REG_A3Y: a3y_q <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // global advance: every stage moves unless a result is stuck at the output
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // valid bits of the five arithmetic stages
  logic [4:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  // stage 1: matrix entries and all squares
  logic signed [AW-1:0]  a00_q, a01_q, a10_q, a11_q;
  logic signed [SQW-1:0] s1x_q, s1y_q, s2x_q, s2y_q, s3x_q, s3y_q;
  logic signed [RSW-1:0] r1s_q, r2s_q, r3s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a00_q <= AW'(-2) * (AW'(a1x_q) - AW'(a3x_q));
      a01_q <= AW'(-2) * (AW'(a1y_q) - AW'(a3y_q));
      a10_q <= AW'(-2) * (AW'(a2x_q) - AW'(a3x_q));
      a11_q <= AW'(-2) * (AW'(a2y_q) - AW'(a3y_q));
      s1x_q <= SQW'(a1x_q) * SQW'(a1x_q);
      s1y_q <= SQW'(a1y_q) * SQW'(a1y_q);
      s2x_q <= SQW'(a2x_q) * SQW'(a2x_q);
      s2y_q <= SQW'(a2y_q) * SQW'(a2y_q);
      s3x_q <= SQW'(a3x_q) * SQW'(a3x_q);
      s3y_q <= SQW'(a3y_q) * SQW'(a3y_q);
      r1s_q <= $signed(RSW'(range_a_i) * RSW'(range_a_i));
      r2s_q <= $signed(RSW'(range_b_i) * RSW'(range_b_i));
      r3s_q <= $signed(RSW'(range_c_i) * RSW'(range_c_i));
    end
  end

  // stage 2: right-hand side and determinant products
  logic signed [BW-1:0] b0_q, b1_q;
  logic signed [PW-1:0] pd0_q, pd1_q;
  logic signed [AW-1:0] a00_2q, a01_2q, a10_2q, a11_2q;
  logic signed [BW-1:0] base;

  assign base = BW'(s3x_q) + BW'(s3y_q) - BW'(r3s_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q   <= base - BW'(s1x_q) - BW'(s1y_q) + BW'(r1s_q);
      b1_q   <= base - BW'(s2x_q) - BW'(s2y_q) + BW'(r2s_q);
      pd0_q  <= PW'(a00_q) * PW'(a11_q);
      pd1_q  <= PW'(a01_q) * PW'(a10_q);
      a00_2q <= a00_q;
      a01_2q <= a01_q;
      a10_2q <= a10_q;
      a11_2q <= a11_q;
    end
  end

  // stage 3: determinant and numerator products
  logic signed [DW-1:0] det_q;
  logic signed [XW-1:0] px0_q, px1_q, py0_q, py1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= DW'(pd0_q) - DW'(pd1_q);
      px0_q <= XW'(b0_q) * XW'(a11_2q);
      px1_q <= XW'(a01_2q) * XW'(b1_q);
      py0_q <= XW'(a00_2q) * XW'(b1_q);
      py1_q <= XW'(b0_q) * XW'(a10_2q);
    end
  end

  // stage 4: numerators
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [DW-1:0] det_4q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= NW'(px0_q) - NW'(px1_q);
      ny_q   <= NW'(py0_q) - NW'(py1_q);
      det_4q <= det_q;
    end
  end

  // stage 5: rounding offset, magnitudes, signs and singular flag
  logic [NW-1:0]  mag_nx, mag_ny;
  logic [DW-1:0]  mag_d;
  logic [MW-1:0]  mx_q, my_q;
  logic [D2W-1:0] d2_q;
  logic           negx_q, negy_q, sing_q;

  assign mag_nx = nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
  assign mag_ny = ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
  assign mag_d  = det_4q[DW-1] ? DW'(-det_4q) : DW'(det_4q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= (MW'(mag_nx) << 1) + MW'(mag_d);
      my_q   <= (MW'(mag_ny) << 1) + MW'(mag_d);
      d2_q   <= D2W'(mag_d) << 1;
      negx_q <= nx_q[NW-1] ^ det_4q[DW-1];
      negy_q <= ny_q[NW-1] ^ det_4q[DW-1];
      sing_q <= (det_4q == '0);
    end
  end

  // divider stages, sideband travels alongside
  logic [QB-1:0] qx, qy;
  logic          ovx, ovy;

  tri2d_div #(.MW(MW), .DW(D2W), .QB(QB)) u_div_x (
    .clk_i (clk_i), .en_i (en), .m_i (mx_q), .d_i (d2_q), .q_o (qx), .over_o (ovx)
  );

  tri2d_div #(.MW(MW), .DW(D2W), .QB(QB)) u_div_y (
    .clk_i (clk_i), .en_i (en), .m_i (my_q), .d_i (d2_q), .q_o (qy), .over_o (ovy)
  );

  typedef struct packed {
    logic valid;
    logic negx;
    logic negy;
    logic sing;
  } side_t;

  side_t side_q [QB];
  side_t side_in;

  assign side_in = '{valid: v_q[4], negx: negx_q, negy: negy_q, sing: sing_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QB; i++) side_q[i] <= '0;
    end else if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < QB; i++) side_q[i] <= side_q[i-1];
    end
  end

  // output stage: sign, clamp, status
  side_t          sd;
  logic           satx, saty;
  logic [CW-1:0]  resx, resy;

  assign sd = side_q[QB-1];

  always_comb begin
    if (sd.negx) begin
      satx = ovx || (qx > QB'(LIM));
      resx = satx ? CW'(LIM) : CW'(QB'(-qx));
    end else begin
      satx = ovx || (qx > QB'(LIM - 1));
      resx = satx ? CW'(LIM - 1) : CW'(qx);
    end
    if (sd.negy) begin
      saty = ovy || (qy > QB'(LIM));
      resy = saty ? CW'(LIM) : CW'(QB'(-qy));
    end else begin
      saty = ovy || (qy > QB'(LIM - 1));
      resy = saty ? CW'(LIM - 1) : CW'(qy);
    end
  end

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sd.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sd.sing) begin
        pos_x_o  <= '0;
        pos_y_o  <= '0;
        status_o <= ST_SINGULAR;
      end else begin
        pos_x_o  <= $signed(resx);
        pos_y_o  <= $signed(resy);
        status_o <= (satx || saty) ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `TRI_ASSERT(a_singular_zero,
    (out_valid_o && status_o == ST_SINGULAR) |-> (pos_x_o == '0 && pos_y_o == '0),
    "singular result carries a nonzero position")
  `TRI_ASSERT(a_sat_at_bound,
    (out_valid_o && status_o == ST_SAT) |->
      (pos_x_o == CW'(LIM) || pos_x_o == CW'(LIM - 1) ||
       pos_y_o == CW'(LIM) || pos_y_o == CW'(LIM - 1)),
    "saturated status without a clamped coordinate")
  `TRI_ASSERT(a_enter_stage1, (in_valid_i && in_ready_o) |=> v_q[0],
    "accepted request did not enter the pipeline")
  `TRI_ASSERT_ALWAYS(a_status_code, status_o != 2'd3 || !out_valid_o,
    "undefined status code delivered")

endmodule
